### rtl/safs_pkg.sv
// Shared types and constants for the slot allocator with free stack
`timescale 1ns / 1ps
`default_nettype none

package safs_pkg;

  // fixed field widths
  localparam int OFF_W      = 15;
  localparam int SIZE_W     = 9;
  localparam int STAT_W     = 2;
  localparam int OFF_BYTES  = 2;
  localparam int DCNT_W     = $clog2(OFF_W);

  // element size after reset
  localparam logic [SIZE_W-1:0] ELEM_SIZE_RESET = SIZE_W'(32);

  // result status codes
  typedef logic [STAT_W-1:0] status_t;
  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_EXHAUSTED  = 2'd1;
  localparam status_t STATUS_STACK_FULL = 2'd2;
  localparam status_t STATUS_RANGE      = 2'd3;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_POP,
    S_MUL,
    S_DIV,
    S_FREE,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture input transfer, seed divider
    logic pop;         // read top of free stack, drop count
    logic take_fresh;  // index from bump counter
    logic idx_from_ram;
    logic mul;         // result offset from index times size
    logic set_exhaust;
    logic div_step;
    logic push;
    logic set_range;
    logic set_full;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op;
    logic stack_empty;
    logic stack_full;
    logic fresh_avail;
    logic div_last;
    logic quo_oob;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/slot_allocator_free_stack_core.sv
// Top level of the fixed-size slot allocator with LIFO free stack
//
// Requests arrive on the in_ stream: in_tuser is the opcode (0 allocate,
// 1 free) and in_tdata[14:0] the byte offset to free. Each request gives
// one result on the out_ stream: out_tdata[14:0] the allocated byte offset
// (zero on free or error), out_tuser[1:0] the status (0 ok, 1 heap
// exhausted, 2 free stack full, 3 index out of range).
// The element size is written on the cfg_ channel (always ready) by the user
// only while idle; the block itself does not enforce this. One request is
// in work at a time. An allocate pops the stack top or takes the bump counter
// as its index and multiplies it by the element size, or finds the heap
// exhausted and only sets the status. A free runs the bit-serial divider
// that turns the offset into a slot index one quotient bit per cycle, then
// pushes the index or sets the range or stack-full status. The next request
// is taken in the cycle after the result is loaded.
// The result sits in an output register, so the next request is accepted
// and worked on while a stalled result waits; a finished result then
// waits in the controller until the output register is free.
// Reset (synchronous, active low) empties the free stack, clears the bump
// counter and sets the element size to 32; stack contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module slot_allocator_free_stack_core #(
  parameter int CAPACITY = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // configuration write: element size
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [safs_pkg::SIZE_W-1:0]            cfg_data,
  // request stream
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [8*safs_pkg::OFF_BYTES-1:0]       in_tdata,   // [14:0] free_offset
  input  wire logic                                   in_tuser,   // [0] op
  // result stream
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic      [8*safs_pkg::OFF_BYTES-1:0]       out_tdata,  // [14:0] offset
  output logic      [safs_pkg::STAT_W-1:0]            out_tuser   // [1:0] status
);

  import safs_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [OFF_W-1:0]  res_offset;
  status_t           res_status;

  assign cfg_ready = 1'b1;

  // controller
  safs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  safs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_size   (cfg_data),
    .in_op      (in_tuser),
    .in_offset  (in_tdata[OFF_W-1:0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_offset (res_offset),
    .out_status (res_status)
  );

  // pack result payload
  assign out_tdata = {{(8*OFF_BYTES-OFF_W){1'b0}}, res_offset};
  assign out_tuser = res_status;

  // a result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending output");

  // never pop an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.stack_empty)
    else $error("pop from empty free stack");

  // push only a valid index onto a stack with room
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!sts.stack_full && !sts.quo_oob))
    else $error("illegal push onto free stack");

  // an accepted request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is in work");

endmodule

`default_nettype wire

### rtl/safs_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module safs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/safs_ctrl.sv
// Controller state machine sequencing allocate and free requests
`timescale 1ns / 1ps
`default_nettype none

module safs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire safs_pkg::sts_t  sts,
  output safs_pkg::cmd_t       cmd
);

  import safs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        if (sts.op == OP_FREE) begin
          state_nxt = S_DIV;
        end else if (!sts.stack_empty) begin
          state_nxt = S_POP;
        end else if (sts.fresh_avail) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DONE;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_FREE;
      end
      S_FREE: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START: begin
        if (sts.op == OP_ALLOC) begin
          if (!sts.stack_empty) begin
            cmd.pop = 1'b1;
          end else if (sts.fresh_avail) begin
            cmd.take_fresh = 1'b1;
          end else begin
            cmd.set_exhaust = 1'b1;
          end
        end
      end
      S_POP:  cmd.idx_from_ram = 1'b1;
      S_MUL:  cmd.mul = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_FREE: begin
        if (sts.quo_oob) begin
          cmd.set_range = 1'b1;
        end else if (sts.stack_full) begin
          cmd.set_full = 1'b1;
        end else begin
          cmd.push = 1'b1;
        end
      end
      S_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/safs_dp.sv
// Datapath: counters, free stack, serial divider, multiplier and output register
`timescale 1ns / 1ps
`default_nettype none

module safs_dp #(
  parameter int CAPACITY = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire safs_pkg::cmd_t                cmd,
  output safs_pkg::sts_t                     sts,
  input  wire logic                          cfg_we,
  input  wire logic [safs_pkg::SIZE_W-1:0]   cfg_size,
  input  wire logic                          in_op,
  input  wire logic [safs_pkg::OFF_W-1:0]    in_offset,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [safs_pkg::OFF_W-1:0]    out_offset,
  output safs_pkg::status_t                  out_status
);

  import safs_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PROD_W = IDX_W + SIZE_W;

  // control registers
  logic [SIZE_W-1:0] size_r,  size_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DCNT_W-1:0] dcnt_r,  dcnt_nxt;

  // payload registers
  logic              op_r,     op_nxt;
  logic [SIZE_W-1:0] rem_r,    rem_nxt;
  logic [OFF_W-1:0]  quo_r,    quo_nxt;
  logic [IDX_W-1:0]  idx_r,    idx_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  status_t           res_st_r,  res_st_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  status_t           out_st_r,  out_st_nxt;

  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W+1:0] diff;
  logic              ge;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  cnt_dec;
  logic [IDX_W-1:0]  ram_rd_data;
  logic              out_free;

  // zero size acts as one
  assign size_eff = (size_r == '0) ? SIZE_W'(1) : size_r;

  // one restoring divide step
  assign shifted = {rem_r, quo_r[OFF_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, size_eff};
  assign ge      = ~diff[SIZE_W+1];

  assign prod    = idx_r * size_eff;
  assign cnt_dec = count_r - CNT_W'(1);

  // free stack storage
  safs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (quo_r[IDX_W-1:0]),
    .rd_en   (cmd.pop),
    .rd_addr (cnt_dec[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign out_free = ~out_valid_r | out_ready;

  // next values
  always_comb begin
    size_nxt      = cfg_we ? cfg_size : size_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    dcnt_nxt      = dcnt_r;
    op_nxt        = op_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    idx_nxt       = idx_r;
    res_off_nxt   = res_off_r;
    res_st_nxt    = res_st_r;
    out_off_nxt   = out_off_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    // capture request and seed divider
    if (cmd.load) begin
      op_nxt      = in_op;
      quo_nxt     = in_offset;
      rem_nxt     = '0;
      dcnt_nxt    = '0;
      res_off_nxt = '0;
      res_st_nxt  = STATUS_OK;
    end
    // allocate path
    if (cmd.pop)          count_nxt = cnt_dec;
    if (cmd.take_fresh) begin
      idx_nxt   = fresh_r[IDX_W-1:0];
      fresh_nxt = fresh_r + CNT_W'(1);
    end
    if (cmd.idx_from_ram) idx_nxt = ram_rd_data;
    if (cmd.mul)          res_off_nxt = OFF_W'(prod);
    if (cmd.set_exhaust)  res_st_nxt = STATUS_EXHAUSTED;
    // free path
    if (cmd.div_step) begin
      rem_nxt  = ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
      quo_nxt  = {quo_r[OFF_W-2:0], ge};
      dcnt_nxt = dcnt_r + DCNT_W'(1);
    end
    if (cmd.push)      count_nxt = count_r + CNT_W'(1);
    if (cmd.set_range) res_st_nxt = STATUS_RANGE;
    if (cmd.set_full)  res_st_nxt = STATUS_STACK_FULL;
    // result into output register
    if (cmd.out_load) begin
      out_off_nxt   = res_off_r;
      out_st_nxt    = res_st_r;
      out_valid_nxt = 1'b1;
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= ELEM_SIZE_RESET;
      count_r     <= '0;
      fresh_r     <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    idx_r     <= idx_nxt;
    res_off_r <= res_off_nxt;
    res_st_r  <= res_st_nxt;
    out_off_r <= out_off_nxt;
    out_st_r  <= out_st_nxt;
  end

  // status to controller
  always_comb begin
    sts.op          = op_r;
    sts.stack_empty = (count_r == '0);
    sts.stack_full  = (count_r == CNT_W'(CAPACITY));
    sts.fresh_avail = (fresh_r < CNT_W'(CAPACITY));
    sts.div_last    = (dcnt_r == DCNT_W'(OFF_W - 1));
    sts.quo_oob     = ({1'b0, quo_r} >= (OFF_W + 1)'(CAPACITY));
    sts.out_free    = out_free;
  end

  assign out_valid  = out_valid_r;
  assign out_offset = out_off_r;
  assign out_status = out_st_r;

endmodule

`default_nettype wire
